// ===== src/mmq_pkg.sv =====
// Package for the message match queue: constants, codes and the payload types.
// Used by every module of the block; depends on nothing.
package mmq_pkg;

	localparam int Depth = 32;
	localparam int IdxW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	localparam logic [2:0] WILD_SOURCE = 3'd1;
	localparam logic [2:0] WILD_TAG = 3'd2;
	localparam logic [2:0] WILD_CONTEXT = 3'd4;

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_MATCH = 3'd1,
		ACT_FIND = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_FRONT = 3'd4,
		ACT_BACK = 3'd5,
		ACT_DEL_LAST = 3'd6,
		ACT_UNUSED = 3'd7
	} action_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOID = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [2:0] action;
		logic [15:0] id;
		logic [7:0] cmd;
		logic [15:0] source;
		logic [15:0] dest;
		logic [15:0] tag;
		logic [15:0] context_req;
		logic [31:0] length;
		logic source_any;
		logic tag_any;
		logic context_any;
	} req_t;

	typedef struct packed {
		logic found;
		logic [15:0] hit_id;
		logic [31:0] hit_length;
		logic [1:0] status;
		logic [5:0] entries;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0] cmd;
		logic [15:0] source;
		logic [15:0] dest;
		logic [15:0] tag;
		logic [15:0] context_req;
		logic [31:0] length;
		logic [2:0] wild;
	} entry_t;

	// Per-cell control from the sequencer for the accept and update cycles.
	typedef struct packed {
		logic load;
		logic shift_up;
		logic shift_down;
	} cell_ctl_t;

endpackage

// ===== src/mmq_cell.sv =====
// One queue cell: holds an entry, compares it against the query, shifts to a neighbor.
// Depends on mmq_pkg.
module mmq_cell import mmq_pkg::*; (
	input logic clk,
	input cell_ctl_t ctl,
	input entry_t load_entry,
	input entry_t from_lower,
	input entry_t from_upper,
	input req_t query,
	output entry_t entry,
	output logic hit,
	output logic id_hit
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_entry;
		end else if (ctl.shift_up) begin
			entry_q <= from_lower;
		end else if (ctl.shift_down) begin
			entry_q <= from_upper;
		end
	end

	assign entry = entry_q;
	assign id_hit = entry_q.id == query.id;
	assign hit = entry_q.cmd == query.cmd && entry_q.dest == query.dest
		&& (entry_q.source == query.source || (entry_q.wild & WILD_SOURCE) != 3'd0)
		&& (entry_q.tag == query.tag || (entry_q.wild & WILD_TAG) != 3'd0)
		&& (entry_q.context_req == query.context_req
			|| (entry_q.wild & WILD_CONTEXT) != 3'd0)
		&& entry_q.length >= query.length;

endmodule

// ===== src/message_match_queue.sv =====
// Top level of the message match queue: a row of mmq_cell instances and the sequencer.
// Depends on mmq_pkg and mmq_cell.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries one request
// transaction; the response channel (rsp_valid, rsp_stall, rsp_data) returns exactly one
// response transaction for each. Slot 0 holds the front entry; entries always fill
// slots 0 up to the count minus one.
// In the cycle in which a request is accepted all cells compare their entry with the
// request in parallel, a priority encoder picks the first hit and the picked entry is
// captured; an append loads its cell at that same edge. In the update state that follows
// every cell loads, shifts toward its neighbor or holds, and the response is registered
// in the output register, which raises rsp_valid. req_stall stays high in the update
// state, so no new request is taken before the last one has been through it.
// The block holds one request at a time. While rsp_stall is high the response stays in
// the output register and req_stall stays high; a new request is taken in the cycle in
// which the waiting response is taken.
// After reset the queue is empty and no response is pending; cell contents are not
// cleared, since only slots below the count are ever read.
module message_match_queue import mmq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [CntW-1:0] count_q;
	logic out_valid_q;
	rsp_t out_q;
	logic [IdxW-1:0] pos_q;
	logic any_q;
	entry_t hit_entry_q;

	entry_t cell_entry [Depth];
	logic [Depth-1:0] hit_v;
	logic [Depth-1:0] id_v;
	cell_ctl_t ctl [Depth];
	entry_t new_entry;

	logic sel_any;
	logic [IdxW-1:0] sel_pos;
	logic do_take;
	logic count_dec;
	logic [IdxW-1:0] last_pos;
	logic [IdxW-1:0] pick;
	rsp_t rsp_d;

	assign req_stall = state_q != S_IDLE || (out_valid_q && rsp_stall);

	assign new_entry = '{id: req_data.id, cmd: req_data.cmd, source: req_data.source,
		dest: req_data.dest, tag: req_data.tag, context_req: req_data.context_req,
		length: req_data.length,
		wild: (req_data.source_any ? WILD_SOURCE : 3'd0)
			| (req_data.tag_any ? WILD_TAG : 3'd0)
			| (req_data.context_any ? WILD_CONTEXT : 3'd0)};

	always_comb begin
		logic [Depth-1:0] vec;
		vec = (req_data.action == ACT_MATCH) ? hit_v : id_v;
		sel_any = 1'b0;
		sel_pos = '0;
		for (int i = Depth - 1; i >= 0; i--) begin
			if (vec[i] && CntW'(i) < count_q) begin
				sel_any = 1'b1;
				sel_pos = IdxW'(i);
			end
		end
	end

	assign last_pos = IdxW'(count_q - CntW'(1));
	assign pick = (req_data.action == ACT_DEL_LAST) ? last_pos : sel_pos;

	always_comb begin
		do_take = 1'b0;
		if (state_q == S_UPDATE && count_q != '0) begin
			unique case (req_q.action)
				ACT_REMOVE, ACT_FRONT, ACT_BACK: do_take = any_q;
				ACT_DEL_LAST: do_take = 1'b1;
				default: do_take = 1'b0;
			endcase
		end
	end

	assign count_dec = do_take
		&& (req_q.action == ACT_REMOVE || req_q.action == ACT_DEL_LAST);

	for (genvar g = 0; g < Depth; g++) begin : g_cell
		entry_t lower;
		entry_t upper;
		entry_t load_e;
		assign lower = (g == 0) ? hit_entry_q : cell_entry[(g == 0) ? 0 : g - 1];
		assign upper = cell_entry[(g == Depth - 1) ? g : g + 1];

		always_comb begin
			ctl[g] = '0;
			load_e = req_q.action == ACT_APPEND ? new_entry : hit_entry_q;
			if (state_q == S_IDLE && req_valid && !req_stall
				&& req_data.action == ACT_APPEND && CntW'(g) == count_q) begin
				ctl[g].load = 1'b1;
				load_e = new_entry;
			end else if (do_take) begin
				unique case (req_q.action)
					ACT_FRONT: begin
						if (IdxW'(g) == 0) begin
							ctl[g].load = 1'b1;
							load_e = hit_entry_q;
						end else if (IdxW'(g) <= pos_q) begin
							ctl[g].shift_up = 1'b1;
						end
					end
					ACT_BACK: begin
						if (IdxW'(g) == last_pos) begin
							ctl[g].load = 1'b1;
							load_e = hit_entry_q;
						end else if (IdxW'(g) >= pos_q) begin
							ctl[g].shift_down = 1'b1;
						end
					end
					ACT_REMOVE: begin
						if (IdxW'(g) >= pos_q && IdxW'(g) != last_pos) begin
							ctl[g].shift_down = 1'b1;
						end
					end
					default: ctl[g] = '0;
				endcase
			end
		end

		mmq_cell u_cell (
			.clk(clk),
			.ctl(ctl[g]),
			.load_entry(load_e),
			.from_lower(lower),
			.from_upper(upper),
			.query(req_data),
			.entry(cell_entry[g]),
			.hit(hit_v[g]),
			.id_hit(id_v[g])
		);
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.entries = 6'(count_dec ? count_q - CntW'(1) : count_q);
		if (req_q.action == ACT_APPEND) begin
			rsp_d.status = (count_q == CntW'(Depth) && !any_q) ? ST_FULL : ST_OK;
		end else if (req_q.action == ACT_MATCH) begin
			if (count_q == '0) begin
				rsp_d.status = ST_EMPTY;
			end else if (any_q) begin
				rsp_d.found = 1'b1;
				rsp_d.hit_id = hit_entry_q.id;
				rsp_d.hit_length = hit_entry_q.length;
			end
		end else if (req_q.action == ACT_DEL_LAST) begin
			if (count_q == '0) begin
				rsp_d.status = ST_EMPTY;
			end else begin
				rsp_d.hit_id = hit_entry_q.id;
				rsp_d.hit_length = hit_entry_q.length;
			end
		end else if (req_q.action inside {ACT_FIND, ACT_REMOVE, ACT_FRONT, ACT_BACK}) begin
			if (count_q == '0) begin
				rsp_d.status = ST_EMPTY;
			end else if (!any_q) begin
				rsp_d.status = ST_NOID;
			end else begin
				rsp_d.found = req_q.action == ACT_FIND;
				rsp_d.hit_id = hit_entry_q.id;
				rsp_d.hit_length = hit_entry_q.length;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (state_q == S_UPDATE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && !req_stall) begin
						req_q <= req_data;
						state_q <= S_UPDATE;
						if (req_data.action == ACT_APPEND && count_q < CntW'(Depth)) begin
							count_q <= count_q + CntW'(1);
						end
					end
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
					out_q <= rsp_d;
					if (count_dec) begin
						count_q <= count_q - CntW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Compare-cycle capture: append records whether the queue had room before the
	// count moved; other actions record the first hit, or the last entry for delete.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid && !req_stall) begin
			any_q <= (req_data.action == ACT_APPEND) ? count_q < CntW'(Depth) : sel_any;
			pos_q <= pick;
			hit_entry_q <= cell_entry[pick];
		end else if (state_q == S_UPDATE) begin
			any_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

	property p_full_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CntW'(Depth);
	endproperty
	a_full_bound: assert property (p_full_bound) else $error("count above depth");

	property p_two_cycle;
		@(posedge clk) disable iff (!arst_n) (req_valid && !req_stall) |=> req_stall;
	endproperty
	a_two_cycle: assert property (p_two_cycle) else $error("request accepted twice");

	property p_rsp_after;
		@(posedge clk) disable iff (!arst_n) (req_valid && !req_stall) |=> ##1 rsp_valid;
	endproperty
	a_rsp_after: assert property (p_rsp_after) else $error("no response after request");

	property p_count_step;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_IDLE && !(req_valid && !req_stall)) |=> $stable(count_q);
	endproperty
	a_count_step: assert property (p_count_step) else $error("count moved while idle");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the message match queue: directed table, then random traffic.
// Depends on mmq_pkg and the message_match_queue RTL.
module testbench;
	import mmq_pkg::*;

	localparam int WatchLimit = 20000;

	typedef struct {
		req_t req;
		logic check_typed;
		rsp_t rsp;
	} vector_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	entry_t queue_model[$];
	rsp_t pending_rsp[$];
	vector_t vectors[$];
	int errors;
	int idle_cycles;
	bit calm;
	bit all_sent;

	message_match_queue i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t queue_step(req_t r);
		rsp_t o;
		entry_t e;
		int pos;
		o = '0;
		o.status = ST_OK;
		pos = -1;
		case (r.action)
			ACT_APPEND: begin
				if (queue_model.size() >= Depth) begin
					o.status = ST_FULL;
				end else begin
					e.id = r.id;
					e.cmd = r.cmd;
					e.source = r.source;
					e.dest = r.dest;
					e.tag = r.tag;
					e.context_req = r.context_req;
					e.length = r.length;
					e.wild = (r.source_any ? WILD_SOURCE : 3'd0) |
						(r.tag_any ? WILD_TAG : 3'd0) |
						(r.context_any ? WILD_CONTEXT : 3'd0);
					queue_model.push_back(e);
				end
			end
			ACT_MATCH: begin
				if (queue_model.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					foreach (queue_model[i]) begin
						e = queue_model[i];
						if (!o.found && e.cmd == r.cmd && e.dest == r.dest &&
							(e.source == r.source || (e.wild & WILD_SOURCE) != 0) &&
							(e.tag == r.tag || (e.wild & WILD_TAG) != 0) &&
							(e.context_req == r.context_req ||
							(e.wild & WILD_CONTEXT) != 0) &&
							e.length >= r.length) begin
							o.found = 1'b1;
							o.hit_id = e.id;
							o.hit_length = e.length;
						end
					end
				end
			end
			ACT_FIND, ACT_REMOVE, ACT_FRONT, ACT_BACK: begin
				if (queue_model.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					foreach (queue_model[i])
						if (pos < 0 && queue_model[i].id == r.id)
							pos = i;
					if (pos < 0) begin
						o.status = ST_NOID;
					end else begin
						e = queue_model[pos];
						o.hit_id = e.id;
						o.hit_length = e.length;
						if (r.action == ACT_FIND) begin
							o.found = 1'b1;
						end else begin
							queue_model.delete(pos);
							if (r.action == ACT_FRONT)
								queue_model.push_front(e);
							else if (r.action == ACT_BACK)
								queue_model.push_back(e);
						end
					end
				end
			end
			ACT_DEL_LAST: begin
				if (queue_model.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					e = queue_model.pop_back();
					o.hit_id = e.id;
					o.hit_length = e.length;
				end
			end
			default: ;
		endcase
		o.entries = 6'(queue_model.size());
		return o;
	endfunction

	function automatic req_t random_req(bit tight);
		req_t r;
		int k;
		r = req_t'({$urandom, $urandom, $urandom, $urandom});
		k = $urandom_range(0, 99);
		if (k < 35)
			r.action = ACT_APPEND;
		else if (k < 60)
			r.action = ACT_MATCH;
		else if (k < 97)
			r.action = 3'($urandom_range(ACT_FIND, ACT_DEL_LAST));
		else
			r.action = ACT_UNUSED;
		if (tight) begin
			r.id = 16'($urandom_range(0, 40));
			r.cmd = 8'($urandom_range(0, 3));
			r.source = 16'($urandom_range(0, 3));
			r.dest = 16'($urandom_range(0, 1));
			r.tag = 16'($urandom_range(0, 3));
			r.context_req = 16'($urandom_range(0, 1));
			if ($urandom_range(0, 3) != 0)
				r.length = 32'($urandom_range(0, 100));
		end
		return r;
	endfunction

	function automatic vector_t make_row(action_t a, logic [15:0] id, logic [31:0] len,
		logic typed, logic [1:0] st, logic [5:0] cnt);
		vector_t v;
		v.req = '0;
		v.req.action = a;
		v.req.id = id;
		v.req.length = len;
		v.check_typed = typed;
		v.rsp = '0;
		v.rsp.status = st;
		v.rsp.entries = cnt;
		return v;
	endfunction

	task automatic send(vector_t v);
		rsp_t p;
		req_data <= v.req;
		if (!calm && $urandom_range(0, 99) < 31) begin
			req_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < 31);
		end
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		p = queue_step(v.req);
		if (v.check_typed && p != v.rsp) begin
			$error("typed row disagrees: expected %h got %h", v.rsp, p);
			errors++;
		end
		pending_rsp.push_back(p);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_rsp.size() != 0);
	endtask

	initial begin
		vector_t v;
		errors = 0;
		calm = 1'b0;
		all_sent = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		vectors.push_back(make_row(ACT_MATCH, 16'd0, 32'd0, 1'b1, ST_EMPTY, 6'd0));
		vectors.push_back(make_row(ACT_FIND, 16'd5, 32'd0, 1'b1, ST_EMPTY, 6'd0));
		vectors.push_back(make_row(ACT_REMOVE, 16'd5, 32'd0, 1'b1, ST_EMPTY, 6'd0));
		vectors.push_back(make_row(ACT_DEL_LAST, 16'd0, 32'd0, 1'b1, ST_EMPTY, 6'd0));
		vectors.push_back(make_row(ACT_UNUSED, 16'd0, 32'd0, 1'b1, ST_OK, 6'd0));
		v = make_row(ACT_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 6'd1);
		v.req.cmd = 8'hFF;
		v.req.source = 16'hFFFF;
		v.req.dest = 16'hFFFF;
		v.req.tag = 16'hFFFF;
		v.req.context_req = 16'hFFFF;
		vectors.push_back(v);
		v.req.action = ACT_MATCH;
		v.check_typed = 1'b0;
		vectors.push_back(v);
		v = make_row(ACT_APPEND, 16'd1, 32'd0, 1'b1, ST_OK, 6'd2);
		v.req.source_any = 1'b1;
		v.req.tag_any = 1'b1;
		v.req.context_any = 1'b1;
		vectors.push_back(v);
		v = make_row(ACT_MATCH, 16'd0, 32'd0, 1'b0, ST_OK, 6'd0);
		v.req.source = 16'd77;
		v.req.tag = 16'd9;
		vectors.push_back(v);
		v.req.length = 32'd1;
		vectors.push_back(v);
		vectors.push_back(make_row(ACT_APPEND, 16'hFFFF, 32'd3, 1'b0, ST_OK, 6'd0));
		vectors.push_back(make_row(ACT_FIND, 16'hFFFF, 32'd0, 1'b0, ST_OK, 6'd0));
		vectors.push_back(make_row(ACT_FIND, 16'd9, 32'd0, 1'b1, ST_NOID, 6'd3));
		vectors.push_back(make_row(ACT_BACK, 16'hFFFF, 32'd0, 1'b0, ST_OK, 6'd0));
		vectors.push_back(make_row(ACT_FRONT, 16'd1, 32'd0, 1'b0, ST_OK, 6'd0));
		vectors.push_back(make_row(ACT_REMOVE, 16'hFFFF, 32'd0, 1'b0, ST_OK, 6'd0));
		for (int i = 0; i < 31; i++)
			vectors.push_back(make_row(ACT_APPEND, 16'(100 + i), 32'(i), 1'b0, ST_OK, 6'd0));
		vectors.push_back(make_row(ACT_APPEND, 16'd0, 32'd0, 1'b1, ST_FULL, 6'd32));
		vectors.push_back(make_row(ACT_DEL_LAST, 16'd0, 32'd0, 1'b0, ST_OK, 6'd0));
		foreach (vectors[i])
			send(vectors[i]);

		drain();
		for (int i = 0; i < 800; i++) begin
			calm = (i >= 300 && i < 400);
			if (i == 500)
				drain();
			v.req = random_req(i % 10 != 0);
			v.check_typed = 1'b0;
			send(v);
		end
		req_valid <= 1'b0;
		calm = 1'b0;
		all_sent = 1'b1;
	end

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			rsp_stall <= !calm && $urandom_range(0, 99) < 31;
		end
	end

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$error("response with none expected: %h", rsp_data);
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_data.found !== exp_rsp.found) begin
					$error("found: expected %h actual %h", exp_rsp.found, rsp_data.found);
					errors++;
				end
				if (rsp_data.hit_id !== exp_rsp.hit_id) begin
					$error("hit_id: expected %h actual %h", exp_rsp.hit_id, rsp_data.hit_id);
					errors++;
				end
				if (rsp_data.hit_length !== exp_rsp.hit_length) begin
					$error("hit_length: expected %h actual %h", exp_rsp.hit_length,
						rsp_data.hit_length);
					errors++;
				end
				if (rsp_data.status !== exp_rsp.status) begin
					$error("status: expected %h actual %h", exp_rsp.status, rsp_data.status);
					errors++;
				end
				if (rsp_data.entries !== exp_rsp.entries) begin
					$error("entries: expected %h actual %h", exp_rsp.entries,
						rsp_data.entries);
					errors++;
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (all_sent && pending_rsp.size() == 0) begin
				repeat (10) @(posedge clk);
				if (errors == 0 && pending_rsp.size() == 0)
					$display("SCOREBOARD CLEAN");
				else
					$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule

// ===== sim.f =====
src/mmq_pkg.sv
src/mmq_cell.sv
src/message_match_queue.sv
sim/testbench.sv
